[design/rspu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rspu_pkg;

   // pixel and weight widths
   localparam int unsigned PIXEL_W  = 16;
   localparam int unsigned FRAC_W   = 5;
   localparam int unsigned WEIGHT_W = FRAC_W + 1;

   // weighted lane sums: 16-bit lane times weight up to 32, two terms
   localparam int unsigned SUM_W    = PIXEL_W + WEIGHT_W;

   // red/blue and green lane masks of an RGB565 word
   localparam logic [PIXEL_W-1:0] LANE_RB = 16'hF81F;
   localparam logic [PIXEL_W-1:0] LANE_G  = 16'h07E0;

   // the two weights always add up to this
   localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 6'd32;

   // stream widths; both tdata widths are whole bytes
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 16;

   // flag positions in req_tuser
   localparam int unsigned UBIT_ROW_FIRST = 0;
   localparam int unsigned UBIT_EMIT_TRAIL = 1;

endpackage : rspu_pkg

`default_nettype wire

[design/rgb565_subpixel_row_shift_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  tdata                                     tuser / tlast
// req      in         src_pixel, edge_left, edge_right (48 b)   row_first, emit_trailing / row_last
// rsp      out        out_pixel (16 b)                          run_end / row_done
// csr      in         shift_fraction (5 b), written on csr_wr_en
//
// one item per clock while rsp is ready; a row_last item that asks for a trailing pixel
// holds the input register for a second result, since the single output register takes
// one pixel a cycle; items pass the input register, then are blended into the output register
// synchronous reset clears the valid flags, the phase bit, the held left pixel
// and shift_fraction; a stalled rsp side backs up through both registers

module rgb565_subpixel_row_shift_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // csr
   input  wire logic                                csr_wr_en,
   input  wire logic [rspu_pkg::FRAC_W-1:0]         csr_wr_data,
   // req
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [rspu_pkg::REQ_DATA_W-1:0]     req_tdata,  // src_pixel, edge_left, edge_right
   input  wire logic [rspu_pkg::REQ_USER_W-1:0]     req_tuser,  // row_first, emit_trailing
   input  wire logic                                req_tlast,  // row_last
   // rsp
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [rspu_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // out_pixel
   output logic                                     rsp_tuser,  // run_end
   output logic                                     rsp_tlast   // row_done
);
   import rspu_pkg::*;

   logic [FRAC_W-1:0]  frac_ff;
   logic [PIXEL_W-1:0] left_pixel_ff;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_phase_ff, s1_phase_in;
   logic [PIXEL_W-1:0] s1_left_ff;
   logic [PIXEL_W-1:0] s1_src_ff;
   logic [PIXEL_W-1:0] s1_right_ff;
   logic               s1_two_ff;
   logic               s1_last_ff;

   logic               out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0] out_pixel_ff;
   logic               out_run_end_ff;
   logic               out_row_done_ff;

   logic [PIXEL_W-1:0] req_src, req_eleft, req_eright;
   logic               req_fire, out_free, s1_move, s1_release;
   logic [PIXEL_W-1:0] mix_a, mix_b, mix_out;

   assign req_src    = req_tdata[PIXEL_W-1:0];
   assign req_eleft  = req_tdata[2*PIXEL_W-1:PIXEL_W];
   assign req_eright = req_tdata[3*PIXEL_W-1:2*PIXEL_W];

   // handshake between the two registers
   assign out_free    = !out_valid_ff || rsp_tready;
   assign s1_move     = s1_valid_ff && out_free;
   assign s1_release  = s1_move && (!s1_two_ff || s1_phase_ff);
   assign req_tready  = !s1_valid_ff || s1_release;
   assign req_fire    = req_tvalid && req_tready;

   // phase goes back to zero whenever the input register empties
   assign s1_valid_in  = req_fire ? 1'b1 : (s1_release ? 1'b0 : s1_valid_ff);
   assign s1_phase_in  = req_fire ? 1'b0 :
                         (s1_release ? 1'b0 : (s1_move ? 1'b1 : s1_phase_ff));
   assign out_valid_in = s1_move ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff       <= '0;
         left_pixel_ff <= '0;
         s1_valid_ff   <= 1'b0;
         s1_phase_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            frac_ff <= csr_wr_data;
         end
         if (req_fire) begin
            left_pixel_ff <= req_src;
         end
         s1_valid_ff  <= s1_valid_in;
         s1_phase_ff  <= s1_phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register, left neighbour resolved on accept
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_left_ff  <= req_tuser[UBIT_ROW_FIRST] ? req_eleft : left_pixel_ff;
         s1_src_ff   <= req_src;
         s1_right_ff <= req_eright;
         s1_two_ff   <= req_tlast && req_tuser[UBIT_EMIT_TRAIL];
         s1_last_ff  <= req_tlast;
      end
   end

   // first result blends left with src, trailing one src with right
   assign mix_a = s1_phase_ff ? s1_src_ff   : s1_left_ff;
   assign mix_b = s1_phase_ff ? s1_right_ff : s1_src_ff;

   rspu_mix u_mix (
      .pix_a    (mix_a),
      .pix_b    (mix_b),
      .weight_a (frac_ff),
      .pix_out  (mix_out)
   );

   // output register
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_pixel_ff    <= mix_out;
         out_run_end_ff  <= !s1_two_ff || s1_phase_ff;
         out_row_done_ff <= s1_last_ff && (!s1_two_ff || s1_phase_ff);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;
   assign rsp_tuser  = out_run_end_ff;
   assign rsp_tlast  = out_row_done_ff;

   // checks
   a_phase_needs_item : assert property (@(posedge clock) disable iff (reset)
      s1_phase_ff |-> (s1_valid_ff && s1_two_ff))
      else $error("trailing phase without a two-result item");

   a_row_done_ends_run : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("row_done on a result that is not the last of its item");

   a_row_start_left : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser[UBIT_ROW_FIRST]) |=> (s1_left_ff == $past(req_eleft)))
      else $error("row start did not take edge_left");

endmodule : rgb565_subpixel_row_shift_unit

`default_nettype wire

[design/rspu_mix.sv]
`timescale 1ns / 1ps
`default_nettype none

module rspu_mix (
   input  wire logic [rspu_pkg::PIXEL_W-1:0]  pix_a,
   input  wire logic [rspu_pkg::PIXEL_W-1:0]  pix_b,
   input  wire logic [rspu_pkg::FRAC_W-1:0]   weight_a,
   output logic      [rspu_pkg::PIXEL_W-1:0]  pix_out
);
   import rspu_pkg::*;

   logic [WEIGHT_W-1:0] weight_a_ext;
   logic [WEIGHT_W-1:0] weight_b;
   logic [SUM_W-1:0]    rb_sum;
   logic [SUM_W-1:0]    g_sum;
   logic [SUM_W-1:0]    rb_shr;
   logic [SUM_W-1:0]    g_shr;

   // complementary weights, b gets 1..32
   assign weight_a_ext = {1'b0, weight_a};
   assign weight_b     = WEIGHT_FULL - weight_a_ext;

   // both lane groups at once, no carry can cross lanes
   assign rb_sum = SUM_W'(pix_a & LANE_RB) * SUM_W'(weight_a_ext)
                 + SUM_W'(pix_b & LANE_RB) * SUM_W'(weight_b);
   assign g_sum  = SUM_W'(pix_a & LANE_G) * SUM_W'(weight_a_ext)
                 + SUM_W'(pix_b & LANE_G) * SUM_W'(weight_b);

   // divide by 32 and mask back to the lanes
   assign rb_shr  = rb_sum >> FRAC_W;
   assign g_shr   = g_sum >> FRAC_W;
   assign pix_out = (rb_shr[PIXEL_W-1:0] & LANE_RB) | (g_shr[PIXEL_W-1:0] & LANE_G);

endmodule : rspu_mix

`default_nettype wire

[tb/tb_rgb565_subpixel_row_shift_unit.sv]
`timescale 1ns / 1ps

module tb_rgb565_subpixel_row_shift_unit;
   import rspu_pkg::*;

   localparam int unsigned CLK_PERIOD = 12;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned NUM_PHASES = 8;
   localparam int unsigned ITEMS_PER_PHASE = 144;
   localparam int unsigned DRAIN_CYCLES = 6;

   // lane masks of an RGB565 word
   localparam logic [15:0] RB_LANES = 16'hF81F;
   localparam logic [15:0] G_LANES  = 16'h07E0;
   localparam int unsigned FULL_WEIGHT = 32;

   // idling modes, one per phase in turn
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      logic [15:0] src;
      logic        first;
      logic [15:0] left_edge;
      logic        last;
      logic        trail;
      logic [15:0] right_edge;
   } pixel_item_type;

   typedef struct {
      logic [15:0] pix;
      logic        run_end;
      logic        row_done;
   } blend_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                  csr_wr_en   = 1'b0;
   logic [FRAC_W-1:0]     csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;  // src_pixel, edge_left, edge_right
   logic [REQ_USER_W-1:0] req_tuser   = '0;  // row_first, emit_trailing
   logic                  req_tlast   = 1'b0; // row_last
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // out_pixel
   logic                  rsp_tuser;          // run_end
   logic                  rsp_tlast;          // row_done

   pixel_item_type   pixel_items_q[$];
   blend_result_type blend_results_q[$];

   // predictor state
   logic [15:0]       held_left_pixel = '0;
   logic [FRAC_W-1:0] shift_weight    = '0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned items_sent     = 0;
   int unsigned pixels_checked = 0;
   int unsigned trailing_count = 0;
   int unsigned rows_done      = 0;

   rgb565_subpixel_row_shift_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // lane-wise weighted mix of two RGB565 pixels, weights summing to 32
   function automatic logic [15:0] mix_rgb565(logic [15:0] a, logic [15:0] b,
                                              int unsigned wa, int unsigned wb);
      int unsigned rb_sum;
      int unsigned g_sum;
      rb_sum = (int'(a & RB_LANES) * wa + int'(b & RB_LANES) * wb) >> 5;
      g_sum  = (int'(a & G_LANES) * wa + int'(b & G_LANES) * wb) >> 5;
      return (rb_sum[15:0] & RB_LANES) | (g_sum[15:0] & G_LANES);
   endfunction

   // expected pixels for one accepted item
   task automatic predict_shift(pixel_item_type it);
      blend_result_type r;
      int unsigned      wl;
      int unsigned      wr;
      logic [15:0]      left;
      logic             two;
      wl   = shift_weight;
      wr   = FULL_WEIGHT - wl;
      left = it.first ? it.left_edge : held_left_pixel;
      two  = it.last && it.trail;
      r.pix      = mix_rgb565(left, it.src, wl, wr);
      r.run_end  = !two;
      r.row_done = it.last && !two;
      blend_results_q.push_back(r);
      held_left_pixel = it.src;
      if (two) begin
         r.pix      = mix_rgb565(it.src, it.right_edge, wl, wr);
         r.run_end  = 1'b1;
         r.row_done = 1'b1;
         blend_results_q.push_back(r);
         trailing_count++;
      end
      if (it.last)
         rows_done++;
   endtask

   // driver: presents pending items, predicts on acceptance
   always @(posedge clock) begin : drive_req
      pixel_item_type           it;
      logic [REQ_USER_W-1:0]    flags;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_shift(it);
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pixel_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               it = pixel_items_q.pop_front();
               flags = '0;
               flags[UBIT_ROW_FIRST]  = it.first;
               flags[UBIT_EMIT_TRAIL] = it.trail;
               req_tdata  <= {it.right_edge, it.left_edge, it.src};
               req_tuser  <= flags;
               req_tlast  <= it.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: compare each accepted pixel with the oldest expectation
   always @(posedge clock) begin : check_rsp
      blend_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (blend_results_q.size() == 0) begin
            $display("%0t: unexpected item: pixel %h run_end %b row_done %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            exp_r = blend_results_q.pop_front();
            pixels_checked++;
            if (rsp_tdata !== exp_r.pix) begin
               $display("%0t: out_pixel expected %h actual %h", $time, exp_r.pix, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== exp_r.run_end) begin
               $display("%0t: run_end expected %b actual %b", $time, exp_r.run_end,
                        rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== exp_r.row_done) begin
               $display("%0t: row_done expected %b actual %b", $time, exp_r.row_done,
                        rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d pixels outstanding", $time, blend_results_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic add_item(logic [15:0] src, logic first, logic [15:0] left_edge,
                           logic last, logic trail, logic [15:0] right_edge);
      pixel_item_type it;
      it.src        = src;
      it.first      = first;
      it.left_edge  = left_edge;
      it.last       = last;
      it.trail      = trail;
      it.right_edge = right_edge;
      pixel_items_q.push_back(it);
   endtask

   // biased toward the all-zero and all-one pixels
   function automatic logic [15:0] any_pixel();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly whole rows with random content, some loose items in between
   task automatic add_random_items(int unsigned count);
      int unsigned n;
      int unsigned len;
      n = 0;
      while (n < count) begin
         if ($urandom_range(99) < 10) begin
            add_item(any_pixel(), 1'($urandom), any_pixel(), 1'($urandom), 1'($urandom),
                     any_pixel());
            n++;
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
            for (int unsigned k = 0; k < len; k++) begin
               add_item(any_pixel(), k == 0, any_pixel(), k == len - 1, 1'($urandom),
                        any_pixel());
            end
            n += len;
         end
      end
   endtask

   // let everything drain, then allow the pipeline to settle
   task automatic wait_drained();
      @(negedge clock);
      while (pixel_items_q.size() != 0 || req_tvalid || blend_results_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_fraction(logic [FRAC_W-1:0] frac);
      @(posedge clock);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= frac;
      shift_weight  = frac;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
   endtask

   // stimulus
   initial begin
      logic [FRAC_W-1:0] frac;
      idle_mode_type     mode;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: frac = 5'd17;
            1: frac = 5'd0;
            2: frac = 5'd31;
            3: frac = 5'd1;
            4: frac = 5'd16;
            default: frac = 5'($urandom);
         endcase
         write_fraction(frac);

         mode = idle_mode_type'(p % 4);
         case (mode)
            IDLE_NONE: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
               send_idle_pct  = 79;
               recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               send_idle_pct  = 0;
               recv_stall_pct = 79;
            end
            default: begin
               send_idle_pct  = 13;
               recv_stall_pct = 13;
            end
         endcase

         if (p == 0) begin
            // no row start since reset: left neighbour is the cleared held pixel
            add_item(16'hFFFF, 1'b0, 16'h1234, 1'b0, 1'b0, 16'h0000);
            // row start takes edge_left
            add_item(16'h0000, 1'b1, 16'hFFFF, 1'b0, 1'b0, 16'h0000);
            add_item(16'hF800, 1'b0, 16'h0000, 1'b0, 1'b0, 16'hFFFF);
            // last pixel without trailing
            add_item(16'h07E0, 1'b0, 16'hFFFF, 1'b1, 1'b0, 16'hFFFF);
            // no row start after a row: previous row's last pixel; trailing off row end
            add_item(16'h001F, 1'b0, 16'h0000, 1'b0, 1'b1, 16'hFFFF);
            add_item(16'hFFFF, 1'b0, 16'h0000, 1'b1, 1'b1, 16'h0000);
            // single-pixel rows, with and without trailing
            add_item(16'hFFFF, 1'b1, 16'h0000, 1'b1, 1'b1, 16'h0000);
            add_item(16'h0000, 1'b1, 16'hFFFF, 1'b1, 1'b0, 16'h5555);
            add_item(16'h0000, 1'b1, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
            // lane extremes
            add_item(16'h07E0, 1'b1, 16'hF81F, 1'b0, 1'b0, 16'h0000);
            add_item(16'hF81F, 1'b0, 16'h07E0, 1'b0, 1'b1, 16'hAAAA);
            add_item(16'hAAAA, 1'b0, 16'h5555, 1'b0, 1'b0, 16'h5555);
            add_item(16'h5555, 1'b0, 16'hAAAA, 1'b1, 1'b1, 16'hAAAA);
            add_item(16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
         end
         add_random_items(ITEMS_PER_PHASE);
         wait_drained();
      end

      if (blend_results_q.size() != 0) begin
         $display("%0t: %0d expected pixels never arrived", $time, blend_results_q.size());
         mismatch_count++;
      end

      $display("Sent %0d items over %0d rows in %0d phases; checked %0d pixels,",
               items_sent, rows_done, NUM_PHASES, pixels_checked);
      $display("%0d of them trailing, across fractions 0, 1, 16, 17, 31 and random ones.",
               trailing_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[filelist.f]
design/rspu_pkg.sv
design/rspu_mix.sv
design/rgb565_subpixel_row_shift_unit.sv
tb/tb_rgb565_subpixel_row_shift_unit.sv
